FILE: hw/rtl/ght_pkg.sv
package ght_pkg;

    // Stream payload widths (fields packed from bit 0, tdata padded to whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 4;

    typedef enum logic [2:0] {
        CMD_NOOP     = 3'd0,
        CMD_RESERVE  = 3'd1,
        CMD_CANCEL   = 3'd2,
        CMD_OPEN     = 3'd3,
        CMD_WRITE    = 3'd4,
        CMD_TRUNCATE = 3'd5,
        CMD_CLOSE    = 3'd6,
        CMD_UNSUP    = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_FULL      = 4'd1,
        ST_GEN_EXH   = 4'd2,
        ST_STALE     = 4'd3,
        ST_BUSY      = 4'd4,
        ST_BAD_OPEN  = 4'd5,
        ST_OPEN_FAIL = 4'd6,
        ST_IO_FAIL   = 4'd7,
        ST_UNSUP     = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic clear;    // write one reset entry, advance the sweep
        logic capture;  // latch the input beat and launch the slot read
        logic execute;  // apply the command, write back, load the result
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;  // sweep is at the final entry
    } dp_status_t;

endpackage

FILE: hw/rtl/ght_ram.sv
module ght_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ght_ctrl.sv
module ght_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ght_pkg::dp_cmd_t    cmd,
    input  ght_pkg::dp_status_t stat
);

    import ght_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register is free or being drained
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.execute   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: hw/rtl/ght_datapath.sv
module ght_datapath #(
    parameter int ENTRIES  = 256,
    parameter int GEN_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ght_pkg::dp_cmd_t                cmd,
    output ght_pkg::dp_status_t             stat,
    input  logic [ght_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [ght_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic [ght_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [ght_pkg::M_TUSER_W-1:0]   m_tuser
);

    import ght_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int NXT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = NXT_W + 1 + GEN_BITS;
    localparam int CMP_W  = (GEN_BITS > 32) ? GEN_BITS : 32;

    // Input beat fields
    cmd_t        in_cmd;
    logic [15:0] in_idx;
    logic [31:0] in_gen;
    logic        in_range;

    assign in_cmd   = cmd_t'(s_tuser[2:0]);
    assign in_idx   = s_tdata[15:0];
    assign in_gen   = s_tdata[47:16];
    assign in_range = in_idx < 16'(ENTRIES);

    // Captured command
    cmd_t             cmd_reg;
    logic [15:0]      idx_reg;
    logic [31:0]      tgen_reg;
    logic             path_reg;
    logic             ok_reg;
    logic             in_range_reg;
    logic [IDX_W-1:0] addr_reg;

    // Architectural state
    logic [NXT_W-1:0]    list_head_reg;
    logic [NXT_W-1:0]    list_head_next;
    logic [GEN_BITS-1:0] gen_cnt_reg;
    logic [GEN_BITS-1:0] gen_cnt_next;
    logic [NXT_W-1:0]    cnt_reg;
    logic [NXT_W-1:0]    cnt_next;
    logic [NXT_W-1:0]    peak_reg;
    logic [NXT_W-1:0]    peak_next;
    logic                err_reg;
    logic                err_next;
    logic [IDX_W-1:0]    clr_cnt_reg;

    // Result payload
    status_t     status_reg;
    status_t     status_next;
    logic [7:0]  oidx_reg;
    logic [7:0]  oidx_next;
    logic [31:0] ogen_reg;
    logic [31:0] ogen_next;
    logic        oopen_reg;
    logic        oopen_next;

    // Slot memory: {next link, open, generation}
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic                rd_open;
    logic [GEN_BITS-1:0] rd_gen;
    logic [NXT_W-1:0]    rd_next;
    logic                tok_ok;
    logic                full;
    logic                exhausted;
    logic [GEN_BITS-1:0] gen_inc;
    logic [NXT_W-1:0]    cnt_inc;
    logic                exec_we;
    logic [WORD_W-1:0]   exec_wdata;
    logic                open_after;

    assign rd_gen  = ram_rdata[GEN_BITS-1:0];
    assign rd_open = ram_rdata[GEN_BITS];
    assign rd_next = ram_rdata[WORD_W-1 -: NXT_W];

    assign full      = list_head_reg == NXT_W'(ENTRIES);
    assign exhausted = &gen_cnt_reg;
    assign gen_inc   = gen_cnt_reg + GEN_BITS'(1);
    assign cnt_inc   = cnt_reg + NXT_W'(1);
    assign tok_ok    = (tgen_reg != '0) && in_range_reg
                       && (CMP_W'(rd_gen) == CMP_W'(tgen_reg));

    // Read address chosen at capture: the free head for reserve, else the token
    always_comb
    begin
        ram_raddr = '0;
        if (in_cmd == CMD_RESERVE)
        begin
            if (list_head_reg != NXT_W'(ENTRIES))
            begin
                ram_raddr = list_head_reg[IDX_W-1:0];
            end
        end
        else if (in_range)
        begin
            ram_raddr = in_idx[IDX_W-1:0];
        end
    end

    always_comb
    begin
        list_head_next = list_head_reg;
        gen_cnt_next   = gen_cnt_reg;
        cnt_next       = cnt_reg;
        peak_next      = peak_reg;
        err_next       = err_reg;
        exec_we        = 1'b0;
        exec_wdata     = ram_rdata;
        status_next    = ST_OK;
        oidx_next      = idx_reg[7:0];
        ogen_next      = '0;
        case (cmd_reg) inside
            CMD_NOOP:
            begin
                status_next = ST_OK;
            end
            CMD_RESERVE:
            begin
                oidx_next = '0;
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (exhausted)
                begin
                    status_next = ST_GEN_EXH;
                end
                else
                begin
                    // pop the head and stamp it with the next generation
                    list_head_next = rd_next;
                    gen_cnt_next   = gen_inc;
                    exec_we        = 1'b1;
                    exec_wdata     = {NXT_W'(ENTRIES), 1'b0, gen_inc};
                    oidx_next      = 8'(addr_reg);
                    ogen_next      = 32'(gen_inc);
                end
            end
            CMD_CANCEL:
            begin
                if (!tok_ok)
                begin
                    status_next = ST_STALE;
                end
                else if (rd_open)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    list_head_next = NXT_W'(addr_reg);
                    exec_we        = 1'b1;
                    exec_wdata     = {list_head_reg, 1'b0, GEN_BITS'(0)};
                end
            end
            CMD_OPEN:
            begin
                if (!tok_ok || rd_open || !path_reg)
                begin
                    status_next = ST_BAD_OPEN;
                    err_next    = 1'b1;
                end
                else
                begin
                    // the attempt counts toward the peak even if it fails
                    if (cnt_inc > peak_reg)
                    begin
                        peak_next = cnt_inc;
                    end
                    if (ok_reg)
                    begin
                        cnt_next   = cnt_inc;
                        exec_we    = 1'b1;
                        exec_wdata = {rd_next, 1'b1, rd_gen};
                    end
                    else
                    begin
                        status_next = ST_OPEN_FAIL;
                        err_next    = 1'b1;
                    end
                end
            end
            CMD_WRITE, CMD_TRUNCATE:
            begin
                if (!tok_ok)
                begin
                    status_next = ST_STALE;
                    err_next    = 1'b1;
                end
                else if (rd_open && !ok_reg)
                begin
                    status_next = ST_IO_FAIL;
                    err_next    = 1'b1;
                end
            end
            CMD_CLOSE:
            begin
                if (!tok_ok)
                begin
                    status_next = ST_STALE;
                    err_next    = 1'b1;
                end
                else
                begin
                    if (rd_open && (cnt_reg != '0))
                    begin
                        cnt_next = cnt_reg - NXT_W'(1);
                    end
                    list_head_next = NXT_W'(addr_reg);
                    exec_we        = 1'b1;
                    exec_wdata     = {list_head_reg, 1'b0, GEN_BITS'(0)};
                end
            end
            default:
            begin
                status_next = tok_ok ? ST_UNSUP : ST_STALE;
                err_next    = 1'b1;
            end
        endcase
        open_after = exec_we ? exec_wdata[GEN_BITS] : rd_open;
        oopen_next = (cmd_reg != CMD_RESERVE) && in_range_reg && open_after;
    end

    assign ram_we    = cmd.clear || (cmd.execute && exec_we);
    assign ram_waddr = cmd.clear ? clr_cnt_reg : addr_reg;
    assign ram_wdata = cmd.clear ? {NXT_W'(clr_cnt_reg) + NXT_W'(1), 1'b0, GEN_BITS'(0)}
                                 : exec_wdata;

    ght_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.clear_last = clr_cnt_reg == IDX_W'(ENTRIES - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg      <= in_cmd;
            idx_reg      <= in_idx;
            tgen_reg     <= in_gen;
            path_reg     <= s_tdata[48];
            ok_reg       <= s_tdata[49];
            in_range_reg <= in_range;
            addr_reg     <= ram_raddr;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            oidx_reg   <= oidx_next;
            ogen_reg   <= ogen_next;
            oopen_reg  <= oopen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_head_reg <= '0;
            gen_cnt_reg   <= '0;
            cnt_reg       <= '0;
            peak_reg      <= '0;
            err_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.clear && !stat.clear_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.execute)
            begin
                list_head_reg <= list_head_next;
                gen_cnt_reg   <= gen_cnt_next;
                cnt_reg       <= cnt_next;
                peak_reg      <= peak_next;
                err_reg       <= err_next;
            end
        end
    end

    // Counters and flag change only on execute, which waits for the last
    // result to drain, so they are read straight into the beat.
    assign m_tuser = status_reg;
    assign m_tdata = {4'b0000, err_reg, 9'(peak_reg), 9'(cnt_reg), oopen_reg,
                      ogen_reg, oidx_reg};

endmodule

FILE: hw/rtl/generational_handle_table_top.sv
// Generational handle table: ENTRIES slots, each with a generation tag and an
// open bit, free slots kept on a linked list in one slot RAM with a registered
// read port and a separate write port.
// Each command beat is accepted in S_IDLE while the slot (or free-list head)
// address is presented to the RAM; S_EXEC then applies the command from the
// registered read data and writes the slot back, once the output register is
// free or being drained. The read-then-write of the addressed slot means a new
// beat is not accepted until the current one has executed. A finished result
// sits in the output register, so a new beat is taken while it waits; the
// block stalls only when a second result is ready and the first is still
// unclaimed. After reset the block sweeps the RAM, one slot per cycle, to link
// the free list: s_tready stays low until the sweep has reached the last slot.
module generational_handle_table_top #(
    parameter int ENTRIES  = 256,
    parameter int GEN_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // token_index[15:0], token_generation[47:16], has_path[48], outcome_ok[49]
    input  logic [ght_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd[2:0]
    input  logic [ght_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot_index[7:0], slot_generation[39:8], slot_is_open[40],
    // open_count[49:41], peak_count[58:50], error_flag[59]
    output logic [ght_pkg::M_TDATA_W-1:0] m_tdata,
    // status[3:0]
    output logic [ght_pkg::M_TUSER_W-1:0] m_tuser
);

    import ght_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_stat;

    ght_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    ght_datapath #(
        .ENTRIES  (ENTRIES),
        .GEN_BITS (GEN_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // one command in flight: no back-to-back beats
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted while a command is executing");

    // the live count never exceeds the recorded peak
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[49:41] <= m_tdata[58:50]))
        else $error("open count above peak");

    // every open, I/O or unsupported-command failure raises the sticky flag
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_BAD_OPEN || m_tuser == ST_OPEN_FAIL
                     || m_tuser == ST_IO_FAIL || m_tuser == ST_UNSUP)
        |-> m_tdata[59])
        else $error("failure without error flag");

    // a waiting result beat holds steady until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while waiting");
`endif

endmodule
